/* hw/rtl/krg_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the key ripple grid.
// No dependencies; imported by krg_cell and keypress_ripple_grid.
package krg_pkg;

    localparam int MAX_CELLS = 48;
    localparam int MASK_W    = MAX_CELLS;
    localparam int IDX_W     = 6;
    localparam int LVL_W     = 4;
    localparam int CNT_W     = $clog2(MAX_CELLS + 1);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 48;

    localparam logic [LVL_W-1:0] LEVEL_DONE = LVL_W'(10);
    localparam logic [LVL_W-1:0] LEVEL_LAST = LVL_W'(9);

    typedef enum logic [1:0] {
        MODE_SET   = 2'd0,
        MODE_FRAME = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLUMNS = 2'd0,
        CFG_CELLS   = 2'd1,
        CFG_KEYMASK = 2'd2,
        CFG_UNUSED  = 2'd3
    } t_cfg_idx;

    // Control shared by every cell of the chain.
    typedef struct packed {
        logic             load;      // frame start: snapshot into the shift lines
        logic             capt_lr;   // shift lines hold the left/right neighbors
        logic             capt_ud;   // shift lines hold the up/down neighbors
        logic             commit;    // apply the frame
        logic             wr_en;     // single cell write
        logic             clr;       // clear all cells
        logic [IDX_W-1:0] wr_idx;
        logic [LVL_W-1:0] wr_lvl;
        logic [IDX_W-1:0] cols_m1;   // effective column count minus one
        logic [IDX_W-1:0] cell_count;
    } t_cell_ctl;

endpackage

/* hw/rtl/krg_cell.sv */
`timescale 1ns / 1ps
// One cell of the ripple chain: level, two snapshot shift lines and column tracker.
// Depends on krg_pkg.
module krg_cell
    import krg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_index,
    input  t_cell_ctl        i_ctl,
    input  logic [LVL_W-1:0] i_lvl_lo,
    input  logic [LVL_W-1:0] i_lvl_hi,
    input  logic [LVL_W-1:0] i_dn,
    input  logic [LVL_W-1:0] i_up,
    input  logic [IDX_W-1:0] i_col_lo,
    output logic [LVL_W-1:0] o_lvl,
    output logic [LVL_W-1:0] o_dn,
    output logic [LVL_W-1:0] o_up,
    output logic [IDX_W-1:0] o_col,
    output logic             o_nz
);

    logic [LVL_W-1:0] r_lvl, n_lvl;
    logic [LVL_W-1:0] r_dn, r_up;
    logic [LVL_W-1:0] r_lft, r_rgt, r_abv, r_blw;
    logic [IDX_W-1:0] r_col, n_col;
    logic             has_left, has_right, down_ok;
    logic             wb, wr, wl, wa;
    logic [LVL_W-1:0] vb, vr, vl, va, vs;

    // Column position ripples in from the lower neighbor; cell 0 always sees a row end.
    assign n_col = (i_col_lo == i_ctl.cols_m1) ? '0 : i_col_lo + IDX_W'(1);

    assign has_left  = (r_col != '0);
    assign has_right = (r_col != i_ctl.cols_m1);
    assign down_ok   = (i_index < i_ctl.cell_count);

    always_comb begin
        // Upward write from the cell one row below.
        wb = 1'b1;
        vb = LVL_W'(2);
        unique case (r_blw)
            LVL_W'(1), LVL_W'(2): vb = LVL_W'(2);
            LVL_W'(3), LVL_W'(6): vb = LVL_W'(6);
            default:              wb = 1'b0;
        endcase
        // Leftward write from the right neighbor.
        wr = has_right;
        vr = LVL_W'(3);
        unique case (r_rgt)
            LVL_W'(1), LVL_W'(3): vr = LVL_W'(3);
            LVL_W'(5), LVL_W'(7): vr = LVL_W'(7);
            default:              wr = 1'b0;
        endcase
        // Rightward write from the left neighbor.
        wl = has_left;
        vl = LVL_W'(4);
        unique case (r_lft)
            LVL_W'(1), LVL_W'(4): vl = LVL_W'(4);
            LVL_W'(2), LVL_W'(8): vl = LVL_W'(8);
            default:              wl = 1'b0;
        endcase
        // Downward write from the cell one row above.
        wa = down_ok;
        va = LVL_W'(5);
        unique case (r_abv)
            LVL_W'(1), LVL_W'(5): va = LVL_W'(5);
            LVL_W'(4), LVL_W'(9): va = LVL_W'(9);
            default:              wa = 1'b0;
        endcase
        vs = (r_lvl > LEVEL_LAST) ? '0 : LEVEL_DONE;
    end

    // The model writes in index order, so the highest-index writer wins.
    always_comb begin
        n_lvl = r_lvl;
        if (i_ctl.clr) begin
            n_lvl = '0;
        end else if (i_ctl.wr_en) begin
            if (i_ctl.wr_idx == i_index && down_ok) begin
                n_lvl = i_ctl.wr_lvl;
            end
        end else if (i_ctl.commit) begin
            priority if (wb)              n_lvl = vb;
            else if (wr)                  n_lvl = vr;
            else if (r_lvl != '0)         n_lvl = vs;
            else if (wl)                  n_lvl = vl;
            else if (wa)                  n_lvl = va;
            else                          n_lvl = r_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl <= '0;
            r_col <= '0;
        end else begin
            r_lvl <= n_lvl;
            r_col <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_dn  <= i_lvl_lo;
            r_up  <= i_lvl_hi;
            r_abv <= '0;
            r_blw <= '0;
        end else begin
            r_dn <= i_dn;
            r_up <= i_up;
            if (i_ctl.capt_ud) begin
                r_abv <= r_dn;
                r_blw <= r_up;
            end
        end
        if (i_ctl.capt_lr) begin
            r_lft <= r_dn;
            r_rgt <= r_up;
        end
    end

    assign o_lvl = r_lvl;
    assign o_dn  = r_dn;
    assign o_up  = r_up;
    assign o_col = r_col;
    assign o_nz  = (r_lvl != '0);

endmodule

/* hw/rtl/keypress_ripple_grid.sv */
`timescale 1ns / 1ps
// Top level of the key ripple grid: handshakes, configuration and the cell chain.
// Depends on krg_pkg and krg_cell.
//
//  Channel   Direction  Handshake                    Payload
//  input     in         i_in_valid / o_in_ready      i_mode, i_cell_index, i_level
//  result    out        o_out_valid / i_out_ready    o_lit_mask
//  config    in         i_cfg_wr_en (no wait)        i_cfg_index, i_cfg_wdata
//
// A cell write, clear or unused mode goes from the transfer straight to the result stage.
// A frame advance first walks the snapshot shift lines one cell per cycle to reach the
// row above and below, commits the frame and then goes to the result stage.
// The next item is taken once the result sits in the output register.
// Reset is synchronous, active low, clears all levels and loads the register defaults.
module keypress_ripple_grid
    import krg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_mode,
    input  logic [IDX_W-1:0]     i_cell_index,
    input  logic [LVL_W-1:0]     i_level,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [MASK_W-1:0]    o_lit_mask,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_out_valid;
    logic [MASK_W-1:0] r_lit;
    logic [IDX_W-1:0]  r_cols, r_cells;
    logic [MASK_W-1:0] r_keys;

    logic              in_fire;
    logic [IDX_W-1:0]  cols_eff;
    t_cell_ctl         ctl;
    logic [LVL_W-1:0]  w_lvl [MAX_CELLS];
    logic [LVL_W-1:0]  w_dn  [MAX_CELLS];
    logic [LVL_W-1:0]  w_up  [MAX_CELLS];
    logic [IDX_W-1:0]  w_col [MAX_CELLS];
    logic [MASK_W-1:0] w_nz;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign cols_eff   = (r_cols == '0) ? IDX_W'(1) : r_cols;

    always_comb begin
        ctl            = '0;
        ctl.load       = in_fire && (t_mode'(i_mode) == MODE_FRAME);
        ctl.wr_en      = in_fire && (t_mode'(i_mode) == MODE_SET);
        ctl.clr        = in_fire && (t_mode'(i_mode) == MODE_CLEAR);
        ctl.capt_lr    = (r_state == S_RUN) && (r_cnt == CNT_W'(1));
        ctl.capt_ud    = (r_state == S_RUN) && (r_cnt == CNT_W'(cols_eff));
        ctl.commit     = (r_state == S_RUN) && (r_cnt == CNT_W'(MAX_CELLS));
        ctl.wr_idx     = i_cell_index;
        ctl.wr_lvl     = i_level;
        ctl.cols_m1    = cols_eff - IDX_W'(1);
        ctl.cell_count = r_cells;
    end

    for (genvar g = 0; g < MAX_CELLS; g++) begin : g_cell
        logic [LVL_W-1:0] lvl_lo, lvl_hi, dn_in, up_in;
        logic [IDX_W-1:0] col_lo;

        if (g == 0) begin : g_first
            assign lvl_lo = '0;
            assign dn_in  = '0;
            assign col_lo = ctl.cols_m1;
        end else begin : g_mid_lo
            assign lvl_lo = w_lvl[g-1];
            assign dn_in  = w_dn[g-1];
            assign col_lo = w_col[g-1];
        end
        if (g == MAX_CELLS - 1) begin : g_last
            assign lvl_hi = '0;
            assign up_in  = '0;
        end else begin : g_mid_hi
            assign lvl_hi = w_lvl[g+1];
            assign up_in  = w_up[g+1];
        end

        krg_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_index  (IDX_W'(g)),
            .i_ctl    (ctl),
            .i_lvl_lo (lvl_lo),
            .i_lvl_hi (lvl_hi),
            .i_dn     (dn_in),
            .i_up     (up_in),
            .i_col_lo (col_lo),
            .o_lvl    (w_lvl[g]),
            .o_dn     (w_dn[g]),
            .o_up     (w_up[g]),
            .o_col    (w_col[g]),
            .o_nz     (w_nz[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols  <= IDX_W'(12);
            r_cells <= IDX_W'(48);
            r_keys  <= '1;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_COLUMNS: r_cols  <= i_cfg_wdata[IDX_W-1:0];
                CFG_CELLS:   r_cells <= i_cfg_wdata[IDX_W-1:0];
                CFG_KEYMASK: r_keys  <= i_cfg_wdata[MASK_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // In the result stage the valid flag is handled below.
            if (r_out_valid && i_out_ready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (t_mode'(i_mode) == MODE_FRAME) begin
                            r_state <= S_RUN;
                            r_cnt   <= CNT_W'(1);
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_RUN: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(MAX_CELLS)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && (!r_out_valid || i_out_ready)) begin
            r_lit <= w_nz & r_keys;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_lit_mask  = r_lit;

`ifndef SYNTHESIS
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_mode == MODE_FRAME |=> r_state == S_RUN && r_cnt == CNT_W'(1))
        else $error("frame did not start its walk");

    a_short_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_mode != MODE_FRAME |=> r_state == S_EMIT)
        else $error("short item did not go straight to the result stage");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> r_cnt >= CNT_W'(1) && r_cnt <= CNT_W'(MAX_CELLS))
        else $error("frame step counter out of range");

    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_mode == MODE_CLEAR |=> w_nz == '0)
        else $error("clear left a cell non-zero");
`endif

endmodule
